// ----- design/taf_pkg.sv -----
// Shared constants, types and helper functions for the triangle affine transform.
`default_nettype none

package taf_pkg;

  // Coordinate format and derived widths
  localparam int COORD_WIDTH = 32;
  localparam int FRAC_BITS   = 16;
  localparam int IO_W        = 32;
  localparam int SAT_W       = (COORD_WIDTH < 32) ? COORD_WIDTH : 32;
  localparam int PROD_W      = 2 * IO_W;
  localparam int ACC_W       = PROD_W - FRAC_BITS + 2;
  localparam int SUM_W       = SAT_W + 2;
  localparam int RAD_W       = 2 * SAT_W;
  localparam int DIV_N_W     = SAT_W + FRAC_BITS;
  localparam int DIV_D_W     = SAT_W;
  localparam int CNT_W       = $clog2(DIV_N_W + 1);
  localparam int NUM_COEF    = 12;

  // Input action codes
  localparam logic [1:0] ACT_LOAD   = 2'd0;
  localparam logic [1:0] ACT_VERTEX = 2'd1;
  localparam logic [1:0] ACT_NORMAL = 2'd2;
  localparam logic [1:0] ACT_RSVD   = 2'd3;

  // Result kind codes
  localparam logic [1:0] KIND_VERTEX   = 2'd0;
  localparam logic [1:0] KIND_NORMAL   = 2'd1;
  localparam logic [1:0] KIND_CENTROID = 2'd2;

  // Divide by three: with n = a*2^17 + b, n/3 = a*DIV3_HI + (2a + b)/3,
  // and the last term is (2a + b) * DIV3_RCP / 2^20
  localparam logic [15:0] DIV3_HI  = 16'd43690;
  localparam logic [18:0] DIV3_RCP = 19'd349526;

  // Saturation bounds at accumulator width
  localparam logic signed [ACC_W-1:0] SAT_HI =
    {{(ACC_W-SAT_W+1){1'b0}}, {(SAT_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] SAT_LO =
    {{(ACC_W-SAT_W+1){1'b1}}, {(SAT_W-1){1'b0}}};

  // Rounding constant for products
  localparam logic signed [PROD_W-1:0] RND_HALF =
    {{(PROD_W-FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}};

  // Fixed-point one
  localparam logic signed [IO_W-1:0] FX_ONE =
    {{(IO_W-FRAC_BITS-1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};

  // Command to the shared root and divide unit
  typedef struct packed {
    logic start;
    logic is_sqrt;
  } dsu_cmd_t;

  // Clamp a wide signed value into the result range
  function automatic logic signed [IO_W-1:0] sat_io(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] c;
    begin
      if (v > SAT_HI) c = SAT_HI;
      else if (v < SAT_LO) c = SAT_LO;
      else c = v;
      return IO_W'(c);
    end
  endfunction

  // Round a product to FRAC_BITS fraction bits, ties toward plus infinity
  function automatic logic signed [ACC_W-1:0] round_prod(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] t;
    begin
      t = p + RND_HALF;
      return ACC_W'(t >>> FRAC_BITS);
    end
  endfunction

endpackage

`default_nettype wire

// ----- design/taf_if.sv -----
// Valid/ready channel interfaces for input items and result items.
`default_nettype none

interface taf_in_if;
  import taf_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [1:0]             action;
  logic [3:0]             coef_index;
  logic signed [IO_W-1:0] in_x;
  logic signed [IO_W-1:0] in_y;
  logic signed [IO_W-1:0] in_z;

  modport source (output valid, action, coef_index, in_x, in_y, in_z, input ready);
  modport sink   (input valid, action, coef_index, in_x, in_y, in_z, output ready);
endinterface

interface taf_out_if;
  import taf_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [1:0]             kind;
  logic signed [IO_W-1:0] out_x;
  logic signed [IO_W-1:0] out_y;
  logic signed [IO_W-1:0] out_z;
  logic                   run_end;

  modport source (output valid, kind, out_x, out_y, out_z, run_end, input ready);
  modport sink   (input valid, kind, out_x, out_y, out_z, run_end, output ready);
endinterface

`default_nettype wire

// ----- design/taf_mul.sv -----
// Registered signed multiplier with fixed-point rounding of its product.
`default_nettype none

module taf_mul (
  input  wire logic                                  clk,
  input  wire logic                                  en,
  input  wire logic signed [taf_pkg::IO_W-1:0]       a,
  input  wire logic signed [taf_pkg::IO_W-1:0]       b,
  output logic signed [taf_pkg::PROD_W-1:0]          prod,
  output logic signed [taf_pkg::ACC_W-1:0]           prod_rnd
);
  import taf_pkg::*;

  logic signed [PROD_W-1:0] prod_r;

  // Capture the exact product
  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= PROD_W'(a) * PROD_W'(b);
    end
  end

  assign prod     = prod_r;
  assign prod_rnd = round_prod(prod_r);

endmodule

`default_nettype wire

// ----- design/taf_dsu.sv -----
// Iterative square root and restoring divider sharing one compare-subtract.
`default_nettype none

module taf_dsu (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire taf_pkg::dsu_cmd_t              cmd,
  input  wire logic [taf_pkg::RAD_W-1:0]      rad,
  input  wire logic [taf_pkg::DIV_N_W-1:0]    num,
  input  wire logic [taf_pkg::DIV_D_W-1:0]    den,
  output logic                                done,
  output logic [taf_pkg::DIV_N_W-1:0]         quo,
  output logic [taf_pkg::DIV_D_W-1:0]         root
);
  import taf_pkg::*;

  localparam logic [RAD_W-1:0] BIT_TOP = {2'b01, {(RAD_W-2){1'b0}}};

  logic               busy_r;
  logic               done_r;
  logic               sqrt_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [RAD_W-1:0]   s_r;
  logic [RAD_W-1:0]   r_r;
  logic [RAD_W-1:0]   bit_r;
  logic [DIV_N_W-1:0] num_r;
  logic [DIV_D_W-1:0] rem_r;
  logic [DIV_D_W-1:0] den_r;

  logic [DIV_D_W:0]   shifted;
  logic [RAD_W-1:0]   lhs;
  logic [RAD_W-1:0]   rhs;
  logic [RAD_W:0]     diff;
  logic               ge;

  // Shared compare-subtract
  always_comb begin
    shifted = {rem_r, num_r[DIV_N_W-1]};
    lhs     = sqrt_r ? s_r : RAD_W'(shifted);
    rhs     = sqrt_r ? (r_r + bit_r) : RAD_W'(den_r);
    diff    = {1'b0, lhs} - {1'b0, rhs};
    ge      = ~diff[RAD_W];
  end

  // Load on start, one digit per cycle while busy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (cmd.start) begin
        busy_r <= 1'b1;
        sqrt_r <= cmd.is_sqrt;
        if (cmd.is_sqrt) begin
          s_r   <= rad;
          r_r   <= '0;
          bit_r <= BIT_TOP;
          cnt_r <= CNT_W'(SAT_W - 1);
        end else begin
          num_r <= num;
          rem_r <= '0;
          den_r <= den;
          cnt_r <= CNT_W'(DIV_N_W - 1);
        end
      end else if (busy_r) begin
        if (sqrt_r) begin
          if (ge) begin
            s_r <= diff[RAD_W-1:0];
            r_r <= (r_r >> 1) + bit_r;
          end else begin
            r_r <= r_r >> 1;
          end
          bit_r <= bit_r >> 2;
        end else begin
          rem_r <= ge ? diff[DIV_D_W-1:0] : shifted[DIV_D_W-1:0];
          num_r <= {num_r[DIV_N_W-2:0], ge};
        end
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = num_r;
  assign root = r_r[DIV_D_W-1:0];

endmodule

`default_nettype wire

// ----- design/triangle_affine_transform_top.sv -----
// Top level: 3x4 affine vertex transform with triangle centroid and normal renormalization.
//
// One item at a time; in_ch.ready is high only while the block is idle. A vertex runs
// nine products through one shared multiplier, one per cycle, then adds the translation
// and stores the beat; the next item can be taken once the beat is stored. The third
// vertex of a triangle then goes on to the centroid: three divides by three (one per
// cycle) and a store. A normal runs nine products, three squares, a 32-step square
// root and three 48-step divides in the one-step-per-cycle root and divide unit; a
// zero-length normal is stored without the root and the divides. Results sit in an
// output register, so the block moves on once a beat is stored, not once it is taken;
// a store waits only while the previous beat is still held.
`default_nettype none

module triangle_affine_transform_top (
  input  wire logic clk,
  input  wire logic rst_n,
  taf_in_if.sink    in_ch,
  taf_out_if.source out_ch
);
  import taf_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE, ST_MUL, ST_SQ, ST_ROOT, ST_DIV, ST_ACC, ST_EMIT, ST_CEN
  } state_t;

  state_t                  state_r;
  logic signed [IO_W-1:0]  mat_r [NUM_COEF];
  logic signed [IO_W-1:0]  v_r [3];
  logic signed [IO_W-1:0]  res_r [3];
  logic signed [SUM_W-1:0] csum_r [3];
  logic [1:0]              vcnt_r;
  logic                    is_norm_r;
  logic                    issue_on_r;
  logic [1:0]              row_r;
  logic [1:0]              col_r;
  logic                    tag_vld_r;
  logic [1:0]              tag_row_r;
  logic [1:0]              tag_col_r;
  logic signed [ACC_W-1:0] acc_r;
  logic [RAD_W-1:0]        sq_acc_r;
  logic [DIV_D_W-1:0]      len_r;
  logic [1:0]              idx_r;
  logic                    div_go_r;
  logic                    cen_pend_r;
  logic [1:0]              emit_kind_r;
  logic                    emit_end_r;
  logic                    out_valid_r;
  logic [1:0]              out_kind_r;
  logic signed [IO_W-1:0]  out_x_r;
  logic signed [IO_W-1:0]  out_y_r;
  logic signed [IO_W-1:0]  out_z_r;
  logic                    out_end_r;

  logic                    in_fire;
  logic                    out_free;
  logic                    mul_en;
  logic signed [IO_W-1:0]  mul_a;
  logic signed [IO_W-1:0]  mul_b;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0] prod_rnd;
  logic signed [ACC_W-1:0] dot_nxt;
  logic signed [ACC_W-1:0] trans;
  logic [RAD_W-1:0]        sq_nxt;
  dsu_cmd_t                dsu_cmd;
  logic [DIV_N_W-1:0]      div_num;
  logic [DIV_D_W-1:0]      div_den;
  logic                    dsu_done;
  logic [DIV_N_W-1:0]      dsu_quo;
  logic [DIV_D_W-1:0]      dsu_root;
  logic signed [IO_W:0]    m_ext;
  logic [IO_W:0]           m_mag;
  logic signed [SUM_W:0]   s_ext;
  logic [SUM_W:0]          s_mag;
  logic                    q_neg;
  logic signed [ACC_W-1:0] q_signed;
  logic                    sq_last;
  logic [32:0]             cen_n;
  logic [17:0]             cen_x;
  logic [37:0]             cen_xm;
  logic [31:0]             cen_q;
  logic signed [ACC_W-1:0] cen_signed;

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;

  // Select multiplier operands: matrix times vertex, or squares of the result
  always_comb begin
    mul_en = issue_on_r && (state_r == ST_MUL || state_r == ST_SQ);
    if (state_r == ST_SQ) begin
      mul_a = res_r[row_r];
      mul_b = res_r[row_r];
    end else begin
      mul_a = mat_r[{row_r, col_r}];
      mul_b = v_r[col_r];
    end
  end

  taf_mul u_mul (
    .clk      (clk),
    .en       (mul_en),
    .a        (mul_a),
    .b        (mul_b),
    .prod     (prod),
    .prod_rnd (prod_rnd)
  );

  // Row sums, square sum, divider operands and the divide by three
  always_comb begin
    dot_nxt = ((tag_col_r == 2'd0) ? '0 : acc_r) + prod_rnd;
    trans   = is_norm_r ? '0 : ACC_W'(mat_r[{tag_row_r, 2'b11}]);
    sq_nxt  = ((tag_row_r == 2'd0) ? '0 : sq_acc_r) + RAD_W'(prod);
    sq_last = (state_r == ST_SQ) && tag_vld_r && (tag_row_r == 2'd2);

    m_ext = (IO_W+1)'(res_r[idx_r]);
    m_mag = (m_ext < 0) ? (IO_W+1)'(-m_ext) : (IO_W+1)'(m_ext);
    s_ext = (SUM_W+1)'(csum_r[idx_r]);
    s_mag = (s_ext < 0) ? (SUM_W+1)'(-s_ext) : (SUM_W+1)'(s_ext);

    div_num  = (DIV_N_W'(m_mag) << FRAC_BITS) + DIV_N_W'(len_r >> 1);
    div_den  = len_r;
    q_neg    = m_ext < 0;
    q_signed = q_neg ? -ACC_W'(dsu_quo) : ACC_W'(dsu_quo);

    // Round the triangle sum to nearest on division by three
    cen_n      = 33'(s_mag) + 33'd1;
    cen_x      = {1'b0, cen_n[32:17], 1'b0} + {1'b0, cen_n[16:0]};
    cen_xm     = 38'(cen_x) * 38'(DIV3_RCP);
    cen_q      = 32'(cen_n[32:17]) * 32'(DIV3_HI) + 32'(cen_xm[37:20]);
    cen_signed = (s_ext < 0) ? -ACC_W'(cen_q) : ACC_W'(cen_q);

    dsu_cmd.is_sqrt = (state_r == ST_SQ);
    dsu_cmd.start   = (sq_last && (sq_nxt != '0)) || (state_r == ST_DIV && div_go_r);
  end

  taf_dsu u_dsu (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (dsu_cmd),
    .rad   (sq_nxt),
    .num   (div_num),
    .den   (div_den),
    .done  (dsu_done),
    .quo   (dsu_quo),
    .root  (dsu_root)
  );

  // Sequencer, state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      for (int i = 0; i < NUM_COEF; i++)
        mat_r[i] <= (i == 0 || i == 5 || i == 10) ? FX_ONE : '0;
      for (int i = 0; i < 3; i++) csum_r[i] <= '0;
      vcnt_r      <= '0;
      issue_on_r  <= 1'b0;
      tag_vld_r   <= 1'b0;
      div_go_r    <= 1'b0;
      cen_pend_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      tag_vld_r <= mul_en;
      tag_row_r <= row_r;
      tag_col_r <= col_r;
      if (out_valid_r && out_ch.ready && state_r != ST_EMIT) out_valid_r <= 1'b0;

      unique case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            unique case (in_ch.action) inside
              ACT_LOAD: begin
                if (in_ch.coef_index < 4'(NUM_COEF)) mat_r[in_ch.coef_index] <= in_ch.in_x;
              end
              ACT_VERTEX, ACT_NORMAL: begin
                v_r[0]     <= in_ch.in_x;
                v_r[1]     <= in_ch.in_y;
                v_r[2]     <= in_ch.in_z;
                is_norm_r  <= (in_ch.action == ACT_NORMAL);
                issue_on_r <= 1'b1;
                row_r      <= '0;
                col_r      <= '0;
                state_r    <= ST_MUL;
              end
              default: ;
            endcase
          end
        end

        ST_MUL: begin
          // Advance the product counters
          if (issue_on_r) begin
            if (col_r == 2'd2) begin
              col_r <= '0;
              if (row_r == 2'd2) issue_on_r <= 1'b0;
              else row_r <= row_r + 2'd1;
            end else begin
              col_r <= col_r + 2'd1;
            end
          end
          // Accumulate the rounded terms of each row
          if (tag_vld_r) begin
            acc_r <= dot_nxt;
            if (tag_col_r == 2'd2) begin
              res_r[tag_row_r] <= sat_io(dot_nxt + trans);
              if (tag_row_r == 2'd2) begin
                if (is_norm_r) begin
                  issue_on_r <= 1'b1;
                  row_r      <= '0;
                  col_r      <= '0;
                  state_r    <= ST_SQ;
                end else begin
                  state_r <= ST_ACC;
                end
              end
            end
          end
        end

        ST_SQ: begin
          if (issue_on_r) begin
            if (row_r == 2'd2) issue_on_r <= 1'b0;
            else row_r <= row_r + 2'd1;
          end
          if (tag_vld_r) sq_acc_r <= sq_nxt;
          if (sq_last) begin
            if (sq_nxt == '0) begin
              emit_kind_r <= KIND_NORMAL;
              emit_end_r  <= 1'b1;
              state_r     <= ST_EMIT;
            end else begin
              state_r <= ST_ROOT;
            end
          end
        end

        ST_ROOT: begin
          if (dsu_done) begin
            len_r    <= dsu_root;
            idx_r    <= '0;
            div_go_r <= 1'b1;
            state_r  <= ST_DIV;
          end
        end

        ST_DIV: begin
          if (div_go_r) begin
            div_go_r <= 1'b0;
          end else if (dsu_done) begin
            res_r[idx_r] <= sat_io(q_signed);
            if (idx_r == 2'd2) begin
              emit_kind_r <= KIND_NORMAL;
              emit_end_r  <= 1'b1;
              state_r     <= ST_EMIT;
            end else begin
              idx_r    <= idx_r + 2'd1;
              div_go_r <= 1'b1;
            end
          end
        end

        ST_CEN: begin
          // Divide one triangle sum by three per cycle
          res_r[idx_r] <= sat_io(cen_signed);
          if (idx_r == 2'd2) begin
            for (int i = 0; i < 3; i++) csum_r[i] <= '0;
            emit_kind_r <= KIND_CENTROID;
            emit_end_r  <= 1'b1;
            state_r     <= ST_EMIT;
          end else begin
            idx_r <= idx_r + 2'd1;
          end
        end

        ST_ACC: begin
          // Add the vertex to the triangle sums and count it
          for (int i = 0; i < 3; i++) csum_r[i] <= csum_r[i] + SUM_W'(res_r[i]);
          if (vcnt_r == 2'd2) begin
            vcnt_r     <= '0;
            cen_pend_r <= 1'b1;
            emit_end_r <= 1'b0;
          end else begin
            vcnt_r     <= vcnt_r + 2'd1;
            emit_end_r <= 1'b1;
          end
          emit_kind_r <= KIND_VERTEX;
          state_r     <= ST_EMIT;
        end

        ST_EMIT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_kind_r  <= emit_kind_r;
            out_x_r     <= res_r[0];
            out_y_r     <= res_r[1];
            out_z_r     <= res_r[2];
            out_end_r   <= emit_end_r;
            if (cen_pend_r) begin
              cen_pend_r <= 1'b0;
              idx_r      <= '0;
              state_r    <= ST_CEN;
            end else begin
              state_r    <= ST_IDLE;
            end
          end
        end

        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign in_ch.ready    = (state_r == ST_IDLE);
  assign out_ch.valid   = out_valid_r;
  assign out_ch.kind    = out_kind_r;
  assign out_ch.out_x   = out_x_r;
  assign out_ch.out_y   = out_y_r;
  assign out_ch.out_z   = out_z_r;
  assign out_ch.run_end = out_end_r;

endmodule

`default_nettype wire

// ----- design/taf_checker.sv -----
// Port-level checks for the triangle affine transform, bound to the top level.
`default_nettype none

module taf_checker (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        in_valid,
  input wire logic                        in_ready,
  input wire logic [1:0]                  in_action,
  input wire logic                        out_valid,
  input wire logic                        out_ready,
  input wire logic [1:0]                  out_kind,
  input wire logic signed [taf_pkg::IO_W-1:0] out_x,
  input wire logic                        out_end
);
  import taf_pkg::*;

  // No result beat right after reset
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result beat shown right after reset");

  // Vertex and normal items hold off the next item
  a_busy_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (in_action == ACT_VERTEX || in_action == ACT_NORMAL))
      |=> !in_ready)
    else $error("block ready right after taking a vertex or normal");

  // Only the vertex before a centroid leaves the run open
  a_open_is_vertex: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_end) |-> (out_kind == KIND_VERTEX))
    else $error("open run on a beat that is not a vertex");

  // A centroid always closes its run
  a_centroid_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind == KIND_CENTROID) |-> out_end)
    else $error("centroid beat without run end");

  // Hold a stalled result beat
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_x) && $stable(out_kind)))
    else $error("stalled result beat changed");

endmodule

bind triangle_affine_transform_top taf_checker u_taf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_action (in_ch.action),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_kind  (out_ch.kind),
  .out_x     (out_ch.out_x),
  .out_end   (out_ch.run_end)
);

`default_nettype wire

// ----- tb/sv/triangle_affine_transform_top_tb.sv -----
// Self-checking testbench for the triangle affine transform: directed table, then random beats.
`default_nettype none

module triangle_affine_transform_top_tb;
  import taf_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITEM_TARGET = 1800;
  localparam int MAX_SHOWN   = 10;

  typedef struct {
    logic [1:0]  kind;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic        last;
  } xform_result_t;

  typedef struct {
    logic [1:0]    action;
    logic [3:0]    idx;
    logic [31:0]   x;
    logic [31:0]   y;
    logic [31:0]   z;
    bit            typed;
    xform_result_t known;
  } stim_row_t;

  logic clk;
  logic rst_n;
  taf_in_if  in_ch();
  taf_out_if out_ch();

  triangle_affine_transform_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Predictor state
  longint      coef_m[NUM_COEF];
  int unsigned tri_count;
  longint      tri_sum[3];

  xform_result_t pending_q[$];
  stim_row_t directed[$];
  int mismatches;
  int n_vertex, n_normal, n_centroid, n_load, n_ignored;
  bit calm;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Watchdog
  initial begin
    #20_000_000;
    $display("FAIL");
    $finish;
  end

  // Append an expected beat at the tail of the queue
  function automatic void queue_result(input xform_result_t r);
    pending_q.insert(pending_q.size(), r);
  endfunction

  // Append a stimulus row to the directed table
  function automatic void add_row(input stim_row_t s);
    directed.insert(directed.size(), s);
  endfunction

  function automatic longint clamp32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Product rounded to Q16.16, ties toward plus infinity
  function automatic longint prod_round(input longint a, input longint b);
    longint p;
    p = a * b + (64'sd1 << (FRAC_BITS - 1));
    return p >>> FRAC_BITS;
  endfunction

  function automatic longint unsigned int_root(input longint unsigned s);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > s) b >>= 2;
    while (b != 0) begin
      if (s >= r + b) begin
        s = s - (r + b);
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint row_term(input int row, input longint v[3], input bit shift);
    longint s;
    s = prod_round(coef_m[row*4], v[0]) + prod_round(coef_m[row*4+1], v[1])
      + prod_round(coef_m[row*4+2], v[2]);
    if (shift) s += coef_m[row*4+3];
    return clamp32(s);
  endfunction

  function automatic xform_result_t mk(input logic [1:0] k, input longint r[3], input logic e);
    xform_result_t o;
    o.kind = k;
    o.x = r[0][31:0];
    o.y = r[1][31:0];
    o.z = r[2][31:0];
    o.last = e;
    return o;
  endfunction

  // Work out the results of one accepted beat and queue them
  task automatic predict_xform(input stim_row_t s);
    longint v[3], r[3], mag, q;
    longint unsigned sq, len, um;
    v[0] = longint'($signed(s.x));
    v[1] = longint'($signed(s.y));
    v[2] = longint'($signed(s.z));
    case (s.action)
      ACT_LOAD: begin
        n_load++;
        if (s.idx < NUM_COEF) coef_m[s.idx] = v[0];
      end
      ACT_VERTEX: begin
        for (int i = 0; i < 3; i++) begin
          r[i] = row_term(i, v, 1'b1);
          tri_sum[i] += r[i];
        end
        tri_count++;
        n_vertex++;
        if (tri_count < 3) begin
          queue_result(mk(KIND_VERTEX, r, 1'b1));
        end else begin
          queue_result(mk(KIND_VERTEX, r, 1'b0));
          for (int i = 0; i < 3; i++) begin
            mag = (tri_sum[i] < 0) ? -tri_sum[i] : tri_sum[i];
            q = (mag + 1) / 3;
            r[i] = clamp32((tri_sum[i] < 0) ? -q : q);
            tri_sum[i] = 0;
          end
          tri_count = 0;
          n_centroid++;
          queue_result(mk(KIND_CENTROID, r, 1'b1));
        end
      end
      ACT_NORMAL: begin
        sq = 0;
        for (int i = 0; i < 3; i++) begin
          r[i] = row_term(i, v, 1'b0);
          um = (r[i] < 0) ? -r[i] : r[i];
          sq += um * um;
        end
        // leave a zero-length normal as it is
        if (sq != 0) begin
          len = int_root(sq);
          for (int i = 0; i < 3; i++) begin
            um = ((r[i] < 0) ? -r[i] : r[i]) << FRAC_BITS;
            um = (um + len / 2) / len;
            r[i] = clamp32((r[i] < 0) ? -longint'(um) : longint'(um));
          end
        end
        n_normal++;
        queue_result(mk(KIND_NORMAL, r, 1'b1));
      end
      default: n_ignored++;
    endcase
  endtask

  // Drive one beat, with a random gap before it, and wait for acceptance
  task automatic send_beat(input stim_row_t s);
    int gap;
    gap = (!calm && $urandom_range(99) < 20) ? $urandom_range(1, 6) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.action     <= s.action;
    in_ch.coef_index <= s.idx;
    in_ch.in_x       <= s.x;
    in_ch.in_y       <= s.y;
    in_ch.in_z       <= s.z;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (s.typed) begin
      predict_xform(s);
      void'(pending_q.pop_back());
      queue_result(s.known);
    end else begin
      predict_xform(s);
    end
  endtask

  // Sink: random backpressure, compare each beat with the oldest expectation
  always @(posedge clk) begin
    xform_result_t e;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (pending_q.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_SHOWN)
            $display("unexpected beat kind=%0d x=%h y=%h z=%h", out_ch.kind,
                     out_ch.out_x, out_ch.out_y, out_ch.out_z);
        end else begin
          e = pending_q.pop_front();
          if (out_ch.kind !== e.kind || out_ch.out_x !== e.x || out_ch.out_y !== e.y ||
              out_ch.out_z !== e.z || out_ch.run_end !== e.last) begin
            mismatches++;
            if (mismatches <= MAX_SHOWN)
              $display("mismatch: exp kind=%0d %h %h %h end=%0b got kind=%0d %h %h %h end=%0b",
                       e.kind, e.x, e.y, e.z, e.last, out_ch.kind, out_ch.out_x,
                       out_ch.out_y, out_ch.out_z, out_ch.run_end);
          end
        end
      end
      out_ch.ready <= calm ? 1'b1 : ($urandom_range(99) >= 20);
    end
  end

  function automatic stim_row_t row(input logic [1:0] a, input logic [3:0] i,
                                    input logic [31:0] x, input logic [31:0] y,
                                    input logic [31:0] z);
    stim_row_t s;
    s.action = a;
    s.idx = i;
    s.x = x;
    s.y = y;
    s.z = z;
    s.typed = 1'b0;
    s.known = '{default: '0};
    return s;
  endfunction

  function automatic stim_row_t typed_row(input stim_row_t s, input logic [1:0] k,
                                          input logic [31:0] x, input logic [31:0] y,
                                          input logic [31:0] z);
    s.typed = 1'b1;
    s.known = '{kind: k, x: x, y: y, z: z, last: 1'b1};
    return s;
  endfunction

  // Random coordinate: mostly modest values, sometimes full range or extremes
  function automatic logic [31:0] rnd_coord();
    int sel;
    sel = $urandom_range(99);
    if (sel < 60) return 32'($signed($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000);
    if (sel < 85) return $urandom;
    if (sel < 90) return 32'h7FFF_FFFF;
    if (sel < 95) return 32'h8000_0000;
    return 32'h0;
  endfunction

  function automatic stim_row_t rnd_row();
    int sel;
    logic [31:0] c;
    sel = $urandom_range(99);
    if (sel < 55) return row(ACT_VERTEX, 4'($urandom), rnd_coord(), rnd_coord(), rnd_coord());
    if (sel < 80) return row(ACT_NORMAL, 4'($urandom), rnd_coord(), rnd_coord(), rnd_coord());
    if (sel < 95) begin
      // coefficients mostly within +-2.0
      c = ($urandom_range(3) == 0) ? $urandom
          : 32'($signed($urandom_range(0, 32'h0003_FFFF)) - 32'sh0002_0000);
      return row(ACT_LOAD, 4'($urandom_range(0, 11)), c, $urandom, $urandom);
    end
    if (sel < 98) return row(ACT_LOAD, 4'($urandom_range(12, 15)), $urandom, $urandom, $urandom);
    return row(ACT_RSVD, 4'($urandom), $urandom, $urandom, $urandom);
  endfunction

  int sent;

  initial begin
    rst_n = 1'b0;
    calm = 1'b0;
    mismatches = 0;
    in_ch.valid = 1'b0;
    in_ch.action = ACT_LOAD;
    in_ch.coef_index = '0;
    in_ch.in_x = '0;
    in_ch.in_y = '0;
    in_ch.in_z = '0;
    for (int i = 0; i < NUM_COEF; i++) coef_m[i] = 0;
    coef_m[0] = 64'sd1 << FRAC_BITS;
    coef_m[5] = 64'sd1 << FRAC_BITS;
    coef_m[10] = 64'sd1 << FRAC_BITS;
    tri_count = 0;
    tri_sum = '{0, 0, 0};
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Identity after reset, zero-length normal, unit normal
    add_row(typed_row(row(ACT_VERTEX, 4'd0, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000),
                      KIND_VERTEX, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000));
    add_row(typed_row(row(ACT_NORMAL, 4'd0, 0, 0, 0), KIND_NORMAL, 0, 0, 0));
    add_row(typed_row(row(ACT_NORMAL, 4'd0, 32'h0002_0000, 0, 0),
                      KIND_NORMAL, 32'h0001_0000, 0, 0));
    add_row(typed_row(row(ACT_VERTEX, 4'hF, 32'h7FFF_FFFF, 32'h8000_0000, 0),
                      KIND_VERTEX, 32'h7FFF_FFFF, 32'h8000_0000, 0));
    // third vertex: vertex then centroid
    add_row(row(ACT_VERTEX, 4'd0, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF));
    // ignored load and unused action
    add_row(row(ACT_LOAD, 4'd12, 32'h1234_5678, 0, 0));
    add_row(row(ACT_LOAD, 4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    add_row(row(ACT_RSVD, 4'hF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    // extreme coefficients, saturated products
    add_row(row(ACT_LOAD, 4'd0, 32'h7FFF_FFFF, 0, 0));
    add_row(row(ACT_LOAD, 4'd3, 32'h8000_0000, 0, 0));
    add_row(row(ACT_LOAD, 4'd11, 32'h7FFF_FFFF, 0, 0));
    add_row(row(ACT_VERTEX, 4'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    add_row(row(ACT_NORMAL, 4'd0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    add_row(row(ACT_VERTEX, 4'd0, 32'h8000_0000, 32'h0000_8000, 32'hFFFF_8000));
    add_row(row(ACT_VERTEX, 4'd0, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_8000));
    add_row(row(ACT_LOAD, 4'd1, 32'hFFFF_0000, 0, 0));
    add_row(row(ACT_LOAD, 4'd6, 32'h0000_8000, 0, 0));
    add_row(row(ACT_NORMAL, 4'd0, 32'h0000_0001, 32'h0000_0001, 32'h0000_0001));
    add_row(row(ACT_VERTEX, 4'd0, 32'h0001_8000, 32'hFFFE_8000, 32'h0000_0003));
    add_row(row(ACT_LOAD, 4'd0, 32'h0001_0000, 0, 0));
    add_row(row(ACT_LOAD, 4'd3, 32'h0000_0000, 0, 0));
    add_row(row(ACT_LOAD, 4'd11, 32'h0000_4000, 0, 0));
    add_row(row(ACT_NORMAL, 4'd0, 32'h0003_0000, 32'h0004_0000, 32'h0000_0000));
    foreach (directed[i]) send_beat(directed[i]);

    // Pause the sender until the block has drained
    in_ch.valid <= 1'b0;
    wait (pending_q.size() == 0);
    @(posedge clk);

    sent = 0;
    while (sent < ITEM_TARGET) begin
      stim_row_t s;
      calm = (sent >= 600 && sent < 800);
      s = rnd_row();
      send_beat(s);
      if (s.action != ACT_RSVD && !(s.action == ACT_LOAD && s.idx >= NUM_COEF)) sent++;
      if (sent == 1200) begin
        in_ch.valid <= 1'b0;
        wait (pending_q.size() == 0);
        @(posedge clk);
      end
    end
    calm = 1'b0;
    in_ch.valid <= 1'b0;

    // Drain, then allow for the longest latency
    wait (pending_q.size() == 0);
    repeat (400) @(posedge clk);
    $display("covered %0d vertices, %0d centroids, %0d normals, %0d loads, %0d ignored beats",
             n_vertex, n_centroid, n_normal, n_load, n_ignored);
    $display("mismatches: %0d, expectations left: %0d", mismatches, pending_q.size());
    if (mismatches == 0 && pending_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- sim.f -----
design/taf_pkg.sv
design/taf_if.sv
design/taf_mul.sv
design/taf_dsu.sv
design/triangle_affine_transform_top.sv
design/taf_checker.sv
tb/sv/triangle_affine_transform_top_tb.sv
